/* hw/rtl/mid128_pkg.sv */
// Package for the Midori128 encryption core: constant tables, shared types and
// the cell substitution helper. It depends on nothing else.
package mid128_pkg;

  // Field and register widths fixed by the interface.
  localparam int unsigned HALF_W      = 64;
  localparam int unsigned BLOCK_W     = 128;
  localparam int unsigned ROUND_W     = 5;
  localparam int unsigned CFG_AW      = 5;
  localparam int unsigned CFG_DW      = 64;
  localparam int unsigned NUM_CELLS   = 16;
  localparam int unsigned MAX_ROUNDS  = 20;
  localparam int unsigned NUM_RC_ROWS = 19;

  // Configuration register indexes (byte address divided by eight).
  localparam logic [1:0] CFG_KEY_HIGH    = 2'd0;
  localparam logic [1:0] CFG_KEY_LOW     = 2'd1;
  localparam logic [1:0] CFG_ROUND_COUNT = 2'd2;

  localparam logic [ROUND_W-1:0] ROUND_COUNT_RST = 5'd20;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_e;

  // Control handed from the sequencer to the round unit.
  typedef struct packed {
    logic               last;
    logic [ROUND_W-1:0] rnd;
  } round_ctrl_t;

  localparam logic [2:0] BIT_PERM [4][8] = '{
    '{3'd4, 3'd1, 3'd6, 3'd3, 3'd0, 3'd5, 3'd2, 3'd7},
    '{3'd1, 3'd6, 3'd7, 3'd0, 3'd5, 3'd2, 3'd3, 3'd4},
    '{3'd2, 3'd3, 3'd4, 3'd1, 3'd6, 3'd7, 3'd0, 3'd5},
    '{3'd7, 3'd4, 3'd1, 3'd2, 3'd3, 3'd0, 3'd5, 3'd6}
  };

  localparam logic [3:0] SB1 [16] = '{
    4'h1, 4'h0, 4'h5, 4'h3, 4'he, 4'h2, 4'hf, 4'h7,
    4'hd, 4'ha, 4'h9, 4'hb, 4'hc, 4'h8, 4'h4, 4'h6
  };

  localparam logic [3:0] SHUFFLE_MAP [16] = '{
    4'd0, 4'd10, 4'd5, 4'd15, 4'd14, 4'd4, 4'd11, 4'd1,
    4'd9, 4'd3, 4'd12, 4'd6, 4'd7, 4'd13, 4'd2, 4'd8
  };

  // One row per round, bit 15 belongs to cell 0.
  localparam logic [15:0] ROUND_CONST [NUM_RC_ROWS] = '{
    16'h15B3, 16'h78C0, 16'hA435, 16'h6213, 16'h104F, 16'hD170, 16'h0266,
    16'h0BCC, 16'h9481, 16'h40B8, 16'h7197, 16'h228E, 16'h5130, 16'hF8CA,
    16'hDF90, 16'h7C81, 16'h1C24, 16'h23B4, 16'h628A
  };

  function automatic logic [15:0] round_const(logic [ROUND_W-1:0] rnd);
    logic [15:0] rc;
    rc = '0;
    if (rnd < ROUND_W'(NUM_RC_ROWS)) begin
      rc = ROUND_CONST[rnd];
    end
    return rc;
  endfunction

  // SSb box: bit permutation, Sb1 on both nibbles, inverse bit permutation.
  // Bit positions count from the most significant bit.
  function automatic logic [7:0] ssb(logic [7:0] x, logic [1:0] sel);
    logic [7:0] y;
    logic [7:0] t;
    logic [7:0] z;
    y = '0;
    z = '0;
    for (int j = 0; j < 8; j++) begin
      y[7-j] = x[7-int'(BIT_PERM[sel][j])];
    end
    t = {SB1[y[7:4]], SB1[y[3:0]]};
    for (int j = 0; j < 8; j++) begin
      z[7-int'(BIT_PERM[sel][j])] = t[7-j];
    end
    return z;
  endfunction

endpackage

/* hw/rtl/mid128_cfg.sv */
// Configuration register file of the Midori128 core behind an APB-style port.
// Depends on mid128_pkg for widths and register indexes.
module mid128_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mid128_pkg::CFG_AW-1:0]      paddr,
  input  logic [mid128_pkg::CFG_DW-1:0]      pwdata,
  output logic [mid128_pkg::CFG_DW-1:0]      prdata,
  output logic                               pready,
  output logic [mid128_pkg::BLOCK_W-1:0]     key_o,
  output logic [mid128_pkg::ROUND_W-1:0]     round_count_o
);

  logic [mid128_pkg::HALF_W-1:0]  key_high_q;
  logic [mid128_pkg::HALF_W-1:0]  key_low_q;
  logic [mid128_pkg::ROUND_W-1:0] round_count_q;
  logic [1:0]                     reg_idx;
  logic                           wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q    <= '0;
      key_low_q     <= '0;
      round_count_q <= mid128_pkg::ROUND_COUNT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        mid128_pkg::CFG_KEY_HIGH:    key_high_q    <= pwdata;
        mid128_pkg::CFG_KEY_LOW:     key_low_q     <= pwdata;
        mid128_pkg::CFG_ROUND_COUNT: round_count_q <= pwdata[mid128_pkg::ROUND_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mid128_pkg::CFG_KEY_HIGH:    prdata = key_high_q;
      mid128_pkg::CFG_KEY_LOW:     prdata = key_low_q;
      mid128_pkg::CFG_ROUND_COUNT: prdata = mid128_pkg::CFG_DW'(round_count_q);
      default:                     prdata = '0;
    endcase
  end

  assign key_o         = {key_high_q, key_low_q};
  assign round_count_o = round_count_q;

endmodule

/* hw/rtl/mid128_round.sv */
// Shared Midori128 round unit: SubCell, then either ShuffleCell, MixColumn and
// key/constant addition, or the final key addition. Depends on mid128_pkg.
module mid128_round (
  input  logic [mid128_pkg::BLOCK_W-1:0] state_i,
  input  logic [mid128_pkg::BLOCK_W-1:0] key_i,
  input  mid128_pkg::round_ctrl_t        ctrl_i,
  output logic [mid128_pkg::BLOCK_W-1:0] state_o
);

  logic [7:0]  sub   [mid128_pkg::NUM_CELLS];
  logic [7:0]  shuf  [mid128_pkg::NUM_CELLS];
  logic [7:0]  mixed [mid128_pkg::NUM_CELLS];
  logic [7:0]  kcell [mid128_pkg::NUM_CELLS];
  logic [15:0] rc;

  assign rc = mid128_pkg::round_const(ctrl_i.rnd);

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      sub[k]   = mid128_pkg::ssb(state_i[127-8*k -: 8], 2'(k));
      kcell[k] = key_i[127-8*k -: 8];
    end
    for (int k = 0; k < 16; k++) begin
      shuf[k] = sub[mid128_pkg::SHUFFLE_MAP[k]];
    end
    // Each cell is replaced by the XOR of the other three cells in its column.
    for (int c = 0; c < 4; c++) begin
      mixed[4*c]   = shuf[4*c+1] ^ shuf[4*c+2] ^ shuf[4*c+3];
      mixed[4*c+1] = shuf[4*c]   ^ shuf[4*c+2] ^ shuf[4*c+3];
      mixed[4*c+2] = shuf[4*c]   ^ shuf[4*c+1] ^ shuf[4*c+3];
      mixed[4*c+3] = shuf[4*c]   ^ shuf[4*c+1] ^ shuf[4*c+2];
    end
    for (int k = 0; k < 16; k++) begin
      if (ctrl_i.last) begin
        state_o[127-8*k -: 8] = sub[k] ^ kcell[k];
      end else begin
        state_o[127-8*k -: 8] = mixed[k] ^ kcell[k] ^ {7'b0, rc[15-k]};
      end
    end
  end

endmodule

/* hw/rtl/midori128_block_encrypt.sv */
// Midori128 block encryption core, top level.
// Uses mid128_pkg, mid128_cfg and mid128_round.

// The core encrypts one 128-bit block per transaction with Midori128, using the
// 128-bit key and round count held in the configuration registers (key_high at
// byte address 0, key_low at 8, round_count at 16). A round count of zero acts
// as one and values above MAX_ROUNDS act as MAX_ROUNDS. After an input
// transaction is taken, the whitened block sits in the state register and one
// shared round unit is applied to it once per clock cycle, the last round
// excepted when it is held: nr-1 full rounds and then the final substitution,
// nr rounds in all (20 with the reset round count), whose result is written
// straight into the output register. in_stall_o is high while a block is in
// progress. The output register decouples the two sides: a new block is taken
// while the previous result still waits, and the core only holds its last
// round when the output register is full and stalled. Configuration may only
// be changed while the core is idle.
module midori128_block_encrypt #(
  parameter int unsigned MAX_ROUNDS = mid128_pkg::MAX_ROUNDS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mid128_pkg::CFG_AW-1:0]      paddr,
  input  logic [mid128_pkg::CFG_DW-1:0]      pwdata,
  output logic [mid128_pkg::CFG_DW-1:0]      prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [mid128_pkg::HALF_W-1:0]      plain_high_i,
  input  logic [mid128_pkg::HALF_W-1:0]      plain_low_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [mid128_pkg::HALF_W-1:0]      cipher_high_o,
  output logic [mid128_pkg::HALF_W-1:0]      cipher_low_o
);

  // The round counter only ever holds values below the round limit.
  localparam int unsigned RND_W = $clog2(MAX_ROUNDS + 1);
  localparam logic [mid128_pkg::ROUND_W-1:0] MAX_NR = mid128_pkg::ROUND_W'(MAX_ROUNDS);

  mid128_pkg::seq_state_e             st_q, st_d;
  logic [RND_W-1:0]                   rnd_q, rnd_d;
  logic [mid128_pkg::BLOCK_W-1:0]     state_q, state_d;
  logic [mid128_pkg::BLOCK_W-1:0]     out_q, out_d;
  logic                               out_valid_q, out_valid_d;
  logic [mid128_pkg::BLOCK_W-1:0]     key;
  logic [mid128_pkg::ROUND_W-1:0]     round_count;
  logic [mid128_pkg::ROUND_W-1:0]     nr;
  logic [mid128_pkg::BLOCK_W-1:0]     round_out;
  mid128_pkg::round_ctrl_t            ctrl;
  logic                               in_acc;
  logic                               out_free;
  logic                               finish;

  mid128_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .key_o         (key),
    .round_count_o (round_count)
  );

  // Effective round count: zero acts as one, large values saturate.
  always_comb begin
    if (round_count == '0) begin
      nr = mid128_pkg::ROUND_W'(1);
    end else if (round_count > MAX_NR) begin
      nr = MAX_NR;
    end else begin
      nr = round_count;
    end
  end

  // The final substitution is due once rnd + 1 reaches the round count.
  assign ctrl.rnd  = mid128_pkg::ROUND_W'(rnd_q);
  assign ctrl.last = (ctrl.rnd + mid128_pkg::ROUND_W'(1)) >= nr;

  mid128_round u_round (
    .state_i (state_q),
    .key_i   (key),
    .ctrl_i  (ctrl),
    .state_o (round_out)
  );

  assign in_stall_o = (st_q != mid128_pkg::ST_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  always_comb begin
    st_d        = st_q;
    rnd_d       = rnd_q;
    state_d     = state_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & out_stall_i;
    finish      = 1'b0;
    unique case (st_q)
      mid128_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = {plain_high_i, plain_low_i} ^ key;
          rnd_d   = '0;
          st_d    = mid128_pkg::ST_RUN;
        end
      end
      mid128_pkg::ST_RUN: begin
        if (!ctrl.last) begin
          state_d = round_out;
          rnd_d   = rnd_q + RND_W'(1);
        end else if (out_free) begin
          // Final round lands straight in the output register.
          finish      = 1'b1;
          out_d       = round_out;
          out_valid_d = 1'b1;
          st_d        = mid128_pkg::ST_IDLE;
        end
      end
      default: st_d = mid128_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= mid128_pkg::ST_IDLE;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
    out_q   <= out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign cipher_high_o = out_q[127:64];
  assign cipher_low_o  = out_q[63:0];

  // The round counter never runs past the effective round count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == mid128_pkg::ST_RUN) |-> (ctrl.rnd < nr))
    else $error("round counter out of range");

  // A taken block starts at round zero in the running state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (st_q == mid128_pkg::ST_RUN) && (rnd_q == '0))
    else $error("block did not start at round zero");

  // Full rounds advance the counter by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == mid128_pkg::ST_RUN) && !ctrl.last |=> (rnd_q == $past(rnd_q) + RND_W'(1)))
    else $error("round counter skipped");

  // A result is only written when the output register can take it,
  // and it then shows as valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |-> (!out_valid_q || !out_stall_i))
    else $error("result overwrote a pending output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> out_valid_o && (st_q == mid128_pkg::ST_IDLE))
    else $error("finished block not presented");

endmodule
